// File: rtl/swmd_pkg.sv
// Package for the sliding-window median deviation block.
// Holds shared constants and the cell control struct; depends on nothing.
package swmd_pkg;

	localparam int WINDOW_MAX_DEF  = 256;
	localparam int SAMPLE_BITS_DEF = 32;
	localparam int COST_BITS       = 40;
	localparam int CFG_BITS        = 9;

	// Control broadcast to every cell of the sorted chain.
	typedef struct packed {
		logic clear;  // empty the chain
		logic del;    // remove one entry equal to the departing sample
		logic ins;    // insert the new sample
	} swmd_ctl_t;

endpackage

// File: rtl/swmd_cell.sv
// One cell of the sorted chain: holds a sample and its occupied flag.
// Depends on swmd_pkg.
module swmd_cell #(
	parameter int SAMPLE_BITS = swmd_pkg::SAMPLE_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  swmd_pkg::swmd_ctl_t    ctl,
	input  logic [SAMPLE_BITS-1:0] new_val,
	input  logic [SAMPLE_BITS-1:0] old_val,
	// Neighbour on the left (smaller index).
	input  logic [SAMPLE_BITS-1:0] left_val,
	input  logic                   left_occ,
	input  logic                   left_hit,
	// Neighbour on the right.
	input  logic [SAMPLE_BITS-1:0] right_val,
	input  logic                   right_occ,
	output logic [SAMPLE_BITS-1:0] val,
	output logic                   occ,
	output logic                   hit
);

	logic [SAMPLE_BITS-1:0] val_q;
	logic                   occ_q;
	logic                   after_del;
	logic [SAMPLE_BITS-1:0] dv;
	logic                   docc;
	logic                   lgt_d;
	logic [SAMPLE_BITS-1:0] lv_d;
	logic                   locc_d;

	assign val = val_q;
	assign occ = occ_q;
	// This cell or one to its left holds the first match of the departing sample.
	assign hit = left_hit || (ctl.del && occ_q && val_q == old_val);

	// Content after removal: cells at or right of the first match take the right value.
	always_comb begin
		after_del = ctl.del && hit;
		dv   = after_del ? right_val : val_q;
		docc = after_del ? right_occ : occ_q;
	end

	// The left neighbour's content after removal, rebuilt locally.
	always_comb begin
		locc_d = left_hit ? occ_q : left_occ;
		lv_d   = left_hit ? val_q : left_val;
		lgt_d  = locc_d && (lv_d > new_val);
	end

	// Insertion: shift right where the left neighbour is already greater.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else if (ctl.clear) begin
			occ_q <= 1'b0;
		end else if (ctl.ins) begin
			occ_q <= docc || locc_d;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (lgt_d) begin
				val_q <= lv_d;
			end else if (!docc || (dv > new_val)) begin
				val_q <= new_val;
			end else begin
				val_q <= dv;
			end
		end
	end

endmodule

// File: rtl/sliding_window_median_deviation.sv
// Top level of the sliding-window median deviation block.
// Depends on swmd_pkg and swmd_cell.
//
// Takes one sample per transfer and returns cost, the sum of absolute deviations of the last
// window_size samples from their median, once the window is full. Samples sit in a sorted
// chain of WINDOW_MAX cells that remove the departing sample and insert the new one in the same
// cycle; a restart or a shrunk window empties the chain at the input transfer itself. The sums
// come from a registered adder tree of 1 + log2(WINDOW_MAX) stages, and the block takes a new
// sample only once the previous result has left (while the window is still filling and no
// result is due, once the sums are done). The arrival ring is a memory whose departing sample
// is registered at the input transfer, ahead of the chain update.
module sliding_window_median_deviation #(
	parameter int WINDOW_MAX  = swmd_pkg::WINDOW_MAX_DEF,
	parameter int SAMPLE_BITS = swmd_pkg::SAMPLE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              window_size_we,
	input  logic [swmd_pkg::CFG_BITS-1:0]     window_size_wdata,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [31:0]                       sample,
	input  logic                              restart,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [swmd_pkg::COST_BITS-1:0]    cost
);

	localparam int PW  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int CW  = $clog2(WINDOW_MAX + 1);
	localparam int LV  = $clog2(WINDOW_MAX);
	localparam int NP  = 1 << LV;
	localparam int CB  = swmd_pkg::COST_BITS;

	typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_SUM, ST_OUT} state_t;

	state_t                  state_q;
	logic [CW-1:0]           k_q;
	logic [CW-1:0]           fill_q;
	logic [PW-1:0]           ptr_q;
	logic [SAMPLE_BITS-1:0]  new_q;
	logic                    rst_q;
	logic [SAMPLE_BITS-1:0]  ring_mem [WINDOW_MAX];
	logic [SAMPLE_BITS-1:0]  old_q;
	logic [CW-1:0]           cnt_q;
	logic [CB-1:0]           cost_q;
	logic [CW-1:0]           lower_len;
	swmd_pkg::swmd_ctl_t     ctl;
	logic                    full_now;
	logic                    clr_now;

	// Configuration register with window size clamp.
	logic [CW-1:0] k_w;
	always_comb begin
		if (window_size_wdata == '0) begin
			k_w = CW'(1);
		end else if ({{32-swmd_pkg::CFG_BITS{1'b0}}, window_size_wdata} > 32'(WINDOW_MAX)) begin
			k_w = CW'(WINDOW_MAX);
		end else begin
			k_w = CW'(window_size_wdata);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= CW'(1);
		end else if (window_size_we) begin
			k_q <= k_w;
		end
	end

	assign in_stall = (state_q != ST_IDLE);
	assign clr_now  = rst_q || (fill_q > k_q);
	assign full_now = !clr_now && (fill_q == k_q);

	// Chain of cells.
	logic [SAMPLE_BITS-1:0] cv   [WINDOW_MAX];
	logic                   co   [WINDOW_MAX];
	logic                   ch   [WINDOW_MAX];

	// The chain is emptied at the input transfer so that the new sample lands in an empty chain.
	always_comb begin
		ctl.clear = (state_q == ST_IDLE) && in_valid && (restart || (fill_q > k_q));
		ctl.del   = full_now;
		ctl.ins   = (state_q == ST_READ);
	end

	// The first cell sees an occupied left neighbour holding zero, so it always fills on insert.
	for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
		logic [SAMPLE_BITS-1:0] lv, rv;
		logic                   lo, lh, ro;
		if (i == 0) begin : g_l0
			assign lv = '0; assign lo = 1'b1; assign lh = 1'b0;
		end else begin : g_l
			assign lv = cv[i-1]; assign lo = co[i-1]; assign lh = ch[i-1];
		end
		if (i == WINDOW_MAX - 1) begin : g_rn
			assign rv = '0; assign ro = 1'b0;
		end else begin : g_r
			assign rv = cv[i+1]; assign ro = co[i+1];
		end
		swmd_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell (
			.clk, .arst_n, .ctl,
			.new_val(new_q), .old_val(old_q),
			.left_val(lv), .left_occ(lo), .left_hit(lh),
			.right_val(rv), .right_occ(ro),
			.val(cv[i]), .occ(co[i]), .hit(ch[i])
		);
	end

	// Signed contribution of each cell: minus in the lower half, plus in the upper.
	// The median of an odd window contributes nothing: its lower-half term is zeroed.
	assign lower_len = CW'((32'(fill_q) + 32'd1) >> 1);
	logic [CB-1:0] tree_s [LV+1][NP];
	always_ff @(posedge clk) begin
		for (int j = 0; j < NP; j++) begin
			if (j >= WINDOW_MAX || !co[j]) begin
				tree_s[0][j] <= '0;
			end else if (fill_q[0] && j == 32'(lower_len) - 1) begin
				tree_s[0][j] <= '0;
			end else if (j < 32'(lower_len)) begin
				tree_s[0][j] <= CB'(0) - CB'(cv[j]);
			end else begin
				tree_s[0][j] <= CB'(cv[j]);
			end
		end
		for (int l = 1; l <= LV; l++) begin
			for (int j = 0; j < NP; j++) begin
				if (j < (NP >> l)) begin
					tree_s[l][j] <= tree_s[l-1][2*j] + tree_s[l-1][2*j+1];
				end else begin
					tree_s[l][j] <= '0;
				end
			end
		end
	end

	// Sequencer and ring pointer bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q  <= '0;
			ptr_q   <= '0;
			cnt_q   <= '0;
			rst_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						rst_q   <= restart;
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					if (clr_now) begin
						fill_q <= CW'(1);
						ptr_q  <= '0;
					end else if (full_now) begin
						ptr_q  <= (32'(ptr_q) == WINDOW_MAX - 1) ? '0 : ptr_q + PW'(1);
					end else begin
						fill_q <= fill_q + CW'(1);
					end
					cnt_q   <= '0;
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					cnt_q <= cnt_q + CW'(1);
					if (32'(cnt_q) == LV + 1) begin
						state_q <= (fill_q == k_q) ? ST_OUT : ST_IDLE;
					end
				end
				ST_OUT: begin
					if (!out_stall) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Sample capture, ring write and the oldest-sample read.
	logic [PW-1:0] wr_idx;
	logic [PW:0]   wr_sum;
	always_comb begin
		wr_sum = (PW+1)'(ptr_q) + (PW+1)'(fill_q);
		if (clr_now) begin
			wr_idx = '0;
		end else if (32'(wr_sum) >= WINDOW_MAX) begin
			wr_idx = PW'(32'(wr_sum) - WINDOW_MAX);
		end else begin
			wr_idx = PW'(wr_sum);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			new_q <= SAMPLE_BITS'(sample);
			old_q <= ring_mem[ptr_q];
		end
		if (state_q == ST_READ) begin
			ring_mem[wr_idx] <= new_q;
		end
		if (state_q == ST_SUM && 32'(cnt_q) == LV + 1) begin
			cost_q <= tree_s[LV][0];
		end
	end

	assign out_valid = (state_q == ST_OUT);
	assign cost      = cost_q;

	// The block never accepts while a result is pending.
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("accept while result pending");
	// Fill count never exceeds WINDOW_MAX, checked while idle.
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (fill_q <= CW'(WINDOW_MAX))) else $error("fill overflow");
	// A result only follows a full window.
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> (fill_q == k_q)) else $error("result from short window");

endmodule

// File: verif/tb_sliding_window_median_deviation.sv
// Testbench for the sliding-window median deviation block.
// Depends on swmd_pkg and the sliding_window_median_deviation RTL; it has a self-contained predictor.
module tb_sliding_window_median_deviation;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WMAX       = swmd_pkg::WINDOW_MAX_DEF;
	localparam int CYCLE_CAP  = 600000;
	localparam int CALM_FROM  = 3000;
	localparam int CALM_TO    = 6000;
	localparam int HOLD_AFTER = 30;
	localparam int HOLD_LEN   = 300;

	typedef struct {
		logic [31:0] value;
		logic        fresh;
	} sample_item_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           window_size_we = 1'b0;
	logic [swmd_pkg::CFG_BITS-1:0]  window_size_wdata = '0;
	logic                           in_valid = 1'b0;
	logic                           in_stall;
	logic [31:0]                    sample = '0;
	logic                           restart = 1'b0;
	logic                           out_valid;
	logic                           out_stall = 1'b0;
	logic [swmd_pkg::COST_BITS-1:0] cost;

	sample_item_t                   pending_samples[$];
	logic [swmd_pkg::COST_BITS-1:0] expected_costs[$];

	// Predictor state: a copy of the window in arrival and in sorted order.
	logic [swmd_pkg::CFG_BITS-1:0]  window_len_reg = 1;
	logic [31:0]          arrival_ring[WMAX];
	logic [31:0]          sorted_vals[$];
	int                   held_count = 0;
	int                   oldest_ptr = 0;

	int cycle_count = 0;
	int error_count = 0;
	int sent_count  = 0;
	int result_count = 0;
	int hold_left = 0;
	bit hold_done = 0;

	sliding_window_median_deviation dut (
		.clk(clk), .arst_n(arst_n),
		.window_size_we(window_size_we), .window_size_wdata(window_size_wdata),
		.in_valid(in_valid), .in_stall(in_stall), .sample(sample), .restart(restart),
		.out_valid(out_valid), .out_stall(out_stall), .cost(cost)
	);

	// Clock generation.
	initial begin
		forever #5 clk = ~clk;
	end

	function automatic bit idle_now();
		if (cycle_count >= CALM_FROM && cycle_count < CALM_TO)
			return 1'b0;
		return $urandom_range(99) < 17;
	endfunction

	// Works out the deviation cost that one accepted sample should give.
	task automatic predict_cost(input logic [31:0] val, input logic fresh);
		int k;
		int pos;
		int lower_len;
		logic [swmd_pkg::COST_BITS-1:0] low_sum;
		logic [swmd_pkg::COST_BITS-1:0] up_sum;
		logic [31:0] leaving;
		k = (window_len_reg == 0) ? 1 : ((window_len_reg > WMAX) ? WMAX : window_len_reg);
		if (fresh || held_count > k) begin
			held_count = 0;
			oldest_ptr = 0;
			sorted_vals.delete();
		end
		if (held_count == k) begin
			leaving = arrival_ring[oldest_ptr];
			foreach (sorted_vals[i]) begin
				if (sorted_vals[i] == leaving) begin
					sorted_vals.delete(i);
					break;
				end
			end
			held_count--;
			oldest_ptr = (oldest_ptr + 1) % WMAX;
		end
		arrival_ring[(oldest_ptr + held_count) % WMAX] = val;
		pos = 0;
		while (pos < sorted_vals.size() && sorted_vals[pos] <= val)
			pos++;
		sorted_vals.insert(pos, val);
		held_count++;
		if (held_count != k)
			return;
		lower_len = (held_count + 1) / 2;
		low_sum = '0;
		up_sum = '0;
		foreach (sorted_vals[i]) begin
			if (i < lower_len)
				low_sum += sorted_vals[i];
			else
				up_sum += sorted_vals[i];
		end
		up_sum = up_sum - low_sum;
		if (k % 2 == 1)
			up_sum += sorted_vals[(k - 1) / 2];
		expected_costs.push_back(up_sum);
	endtask

	// Sender: predicts each transfer and offers the next pending sample.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				predict_cost(sample, restart);
				sent_count++;
			end
			if (!in_valid || !in_stall) begin
				if (pending_samples.size() > 0 && !idle_now()) begin
					in_valid <= 1'b1;
					sample   <= pending_samples[0].value;
					restart  <= pending_samples[0].fresh;
					void'(pending_samples.pop_front());
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: checks each result transfer and stalls at random, once for a long stretch.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				result_count++;
				if (expected_costs.size() == 0) begin
					$error("unexpected result: cost actual %0h", cost);
					error_count++;
				end else begin
					if (cost !== expected_costs[0]) begin
						$error("cost mismatch: expected %0h actual %0h",
							expected_costs[0], cost);
						error_count++;
					end
					void'(expected_costs.pop_front());
				end
			end
			if (!hold_done && result_count == HOLD_AFTER) begin
				hold_done = 1;
				hold_left = HOLD_LEN;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= idle_now();
			end
		end
	end

	// Cycle counter and timeout.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_CAP) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic add_sample(input logic [31:0] val, input logic fresh);
		sample_item_t it;
		it.value = val;
		it.fresh = fresh;
		pending_samples.push_back(it);
	endtask

	// Waits until every transfer has gone and every result has come back, then lets
	// the pipeline drain before a register write.
	task automatic wait_idle();
		while (pending_samples.size() > 0 || in_valid || expected_costs.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic set_window(input int len);
		@(posedge clk);
		window_size_we    <= 1'b1;
		window_size_wdata <= len[swmd_pkg::CFG_BITS-1:0];
		@(posedge clk);
		window_size_we    <= 1'b0;
		window_len_reg = len[swmd_pkg::CFG_BITS-1:0];
	endtask

	// Random sample: full range, a narrow range for ties, or values near the maximum.
	function automatic logic [31:0] rand_sample();
		case ($urandom_range(3))
			0: return $urandom_range(7);
			1: return $urandom() | 32'hFFFF_FFF0;
			default: return $urandom();
		endcase
	endfunction

	int phase_lens[] = '{2, 5, 0, 300, 4, 256, 1, 511, 17, 64, 2, 8, 3, 33, 7};
	int count;

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset window of one, then extremes, ties and restart with three.
		add_sample(32'h0, 1'b0);
		add_sample(32'hFFFF_FFFF, 1'b0);
		wait_idle();
		set_window(3);
		add_sample(32'hFFFF_FFFF, 1'b1);
		add_sample(32'h0, 1'b0);
		add_sample(32'hFFFF_FFFF, 1'b0);
		add_sample(32'hFFFF_FFFF, 1'b0);
		add_sample(32'hFFFF_FFFF, 1'b0);
		add_sample(32'h5, 1'b0);
		add_sample(32'h5, 1'b0);
		add_sample(32'h5, 1'b1);
		add_sample(32'hAAAA_AAAA, 1'b0);
		add_sample(32'h5555_5555, 1'b0);
		add_sample(32'h1, 1'b0);
		wait_idle();

		// Random phases over many window lengths, some without restart on entry
		// so that growing and shrinking windows are covered.
		foreach (phase_lens[p]) begin
			set_window(phase_lens[p]);
			count = (phase_lens[p] >= 64) ?
				((phase_lens[p] > WMAX) ? WMAX : phase_lens[p]) + 20 : 30;
			for (int i = 0; i < count; i++)
				add_sample(rand_sample(),
					(i == 0) ? ($urandom_range(1) == 1) : ($urandom_range(39) == 0));
			wait_idle();
		end

		$display("Covered %0d samples and %0d checked costs over %0d window lengths.",
			sent_count, result_count, phase_lens.size() + 2);
		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

// File: sim.f
rtl/swmd_pkg.sv
rtl/swmd_cell.sv
rtl/sliding_window_median_deviation.sv
verif/tb_sliding_window_median_deviation.sv
